### rtl/cdb_pkg.sv
// ----------------------------------------------------------------------------
// cdb_pkg
// Shared types and codes for the causal delivery buffer.
// ----------------------------------------------------------------------------
package cdb_pkg;

   localparam int SLOTS      = 4;
   localparam int SLOT_WIDTH = 16;
   localparam int VEC_WIDTH  = SLOTS * SLOT_WIDTH;

   typedef enum logic [1:0] {
      KIND_SENT      = 2'd0,
      KIND_DELIVERED = 2'd1,
      KIND_NONE      = 2'd2,
      KIND_DROPPED   = 2'd3
   } kind_type;

   typedef enum logic {
      OP_SEND    = 1'b0,
      OP_RECEIVE = 1'b1
   } op_type;

   localparam logic CSR_MY_PROCESS = 1'b0;
   localparam logic CSR_DEP_MATRIX = 1'b1;

   typedef struct packed {
      op_type                 op;
      logic [1:0]             originator;
      logic [SLOT_WIDTH-1:0]  seq_num;
      logic [VEC_WIDTH-1:0]   clock_vector;
   } cmd_type;

   // handshake between the front queue and the back engine
   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } cmd_link_type;

endpackage

### rtl/cdb_front.sv
// ----------------------------------------------------------------------------
// cdb_front
// Accepts and classifies items and queues them for the back engine.
// ----------------------------------------------------------------------------
module cdb_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic                                req_op,
   input  logic [1:0]                          req_originator,
   input  logic [cdb_pkg::SLOT_WIDTH-1:0]      req_seq_num,
   input  logic [cdb_pkg::VEC_WIDTH-1:0]       req_clock_vector,
   output cdb_pkg::cmd_link_type               link,
   input  logic                                take
);

   cdb_pkg::cmd_type q_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;
   logic             push, pop;
   cdb_pkg::cmd_type new_cmd;

   always_comb begin
      new_cmd.op           = req_op ? cdb_pkg::OP_RECEIVE : cdb_pkg::OP_SEND;
      // originator carries meaning for receive only
      new_cmd.originator   = req_op ? req_originator : 2'd0;
      new_cmd.seq_num      = req_seq_num;
      new_cmd.clock_vector = req_clock_vector;
   end

   assign busy       = (count_ff == 2'd2);
   assign push       = start && !busy;
   assign link.valid = (count_ff != 2'd0);
   assign link.cmd   = q_ff[rd_ptr_ff];
   assign pop        = link.valid && take;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= new_cmd;
      end
   end

endmodule

### rtl/cdb_back.sv
// ----------------------------------------------------------------------------
// cdb_back
// Executes queued items: sends, drops, buffering, ordered scan and delivery.
// ----------------------------------------------------------------------------
module cdb_back #(
   parameter int NUM_PROCESSES = 4,
   parameter int PENDING_DEPTH = 16,
   parameter int CLOCK_WIDTH   = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  cdb_pkg::cmd_link_type               link,
   output logic                                take,
   input  logic [1:0]                          my_process,
   input  logic [cdb_pkg::SLOTS*cdb_pkg::SLOTS-1:0] dep_matrix,
   output logic                                rsp_valid,
   output logic [1:0]                          rsp_kind,
   output logic [1:0]                          rsp_originator_res,
   output logic [cdb_pkg::SLOT_WIDTH-1:0]      rsp_seq_num_res,
   output logic [cdb_pkg::VEC_WIDTH-1:0]       rsp_clock_vector_res,
   output logic                                rsp_last
);

   localparam int IW = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
   localparam int CW = $clog2(PENDING_DEPTH + 1);
   localparam logic [CW-1:0] DEPTH_C = CW'(PENDING_DEPTH);
   localparam logic [CLOCK_WIDTH-1:0] CLOCK_MAX = {CLOCK_WIDTH{1'b1}};
   localparam int SW = cdb_pkg::SLOT_WIDTH;

   typedef struct packed {
      logic [1:0]                      origin;
      logic [SW-1:0]                   seq;
      logic [cdb_pkg::VEC_WIDTH-1:0]   vc;
   } entry_type;

   typedef enum logic {
      ST_IDLE,
      ST_SCAN
   } state_type;

   state_type                state_ff;
   entry_type                pend_ff [PENDING_DEPTH];
   logic [CW-1:0]            count_ff;
   logic [CW-1:0]            k_ff;
   entry_type                hold_ff;
   logic                     have_hold_ff;
   logic [CLOCK_WIDTH-1:0]   lc_ff [cdb_pkg::SLOTS];

   entry_type                cur;
   logic [SW:0]              seq_limit;
   logic                     seq_ok, dep_ok, deliver;
   logic [cdb_pkg::VEC_WIDTH-1:0] send_word;
   logic [CLOCK_WIDTH-1:0]   clk_o;

   assign take = (state_ff == ST_IDLE);
   assign cur  = pend_ff[k_ff[IW-1:0]];
   assign clk_o = lc_ff[cur.origin];

   always_comb begin
      seq_limit = {{(SW+1-CLOCK_WIDTH){1'b0}}, clk_o} + {{SW{1'b0}}, 1'b1};
      seq_ok    = ({1'b0, cur.seq} <= seq_limit);
      dep_ok    = 1'b1;
      for (int j = 0; j < cdb_pkg::SLOTS; j++) begin
         if ((j < NUM_PROCESSES) && dep_matrix[{cur.origin, 2'(j)}] &&
             (cur.vc[j*SW +: SW] > SW'(lc_ff[j]))) begin
            dep_ok = 1'b0;
         end
      end
      deliver = seq_ok && dep_ok;
   end

   always_comb begin
      send_word = '0;
      for (int j = 0; j < cdb_pkg::SLOTS; j++) begin
         if ((j < NUM_PROCESSES) && dep_matrix[{my_process, 2'(j)}]) begin
            send_word[j*SW +: SW] = SW'(lc_ff[j]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         k_ff         <= '0;
         have_hold_ff <= 1'b0;
         rsp_valid    <= 1'b0;
         for (int p = 0; p < cdb_pkg::SLOTS; p++) begin
            lc_ff[p] <= '0;
         end
      end else begin
         rsp_valid <= 1'b0;
         case (state_ff)
            ST_IDLE: begin
               if (link.valid) begin
                  if (link.cmd.op == cdb_pkg::OP_SEND) begin
                     rsp_valid            <= 1'b1;
                     rsp_kind             <= cdb_pkg::KIND_SENT;
                     rsp_originator_res   <= my_process;
                     rsp_seq_num_res      <= link.cmd.seq_num;
                     rsp_clock_vector_res <= send_word;
                     rsp_last             <= 1'b1;
                  end else if (count_ff == DEPTH_C) begin
                     // drop: a full buffer has nothing deliverable
                     rsp_valid            <= 1'b1;
                     rsp_kind             <= cdb_pkg::KIND_DROPPED;
                     rsp_originator_res   <= link.cmd.originator;
                     rsp_seq_num_res      <= link.cmd.seq_num;
                     rsp_clock_vector_res <= link.cmd.clock_vector;
                     rsp_last             <= 1'b1;
                  end else begin
                     pend_ff[count_ff[IW-1:0]] <= '{origin: link.cmd.originator,
                                                   seq:    link.cmd.seq_num,
                                                   vc:     link.cmd.clock_vector};
                     count_ff     <= count_ff + CW'(1);
                     k_ff         <= '0;
                     have_hold_ff <= 1'b0;
                     state_ff     <= ST_SCAN;
                  end
               end
            end
            ST_SCAN: begin
               if (k_ff >= count_ff) begin
                  // scan done: flush the held delivery as last, or report none
                  rsp_valid <= 1'b1;
                  rsp_last  <= 1'b1;
                  if (have_hold_ff) begin
                     rsp_kind             <= cdb_pkg::KIND_DELIVERED;
                     rsp_originator_res   <= hold_ff.origin;
                     rsp_seq_num_res      <= hold_ff.seq;
                     rsp_clock_vector_res <= hold_ff.vc;
                  end else begin
                     rsp_kind             <= cdb_pkg::KIND_NONE;
                     rsp_originator_res   <= '0;
                     rsp_seq_num_res      <= '0;
                     rsp_clock_vector_res <= '0;
                  end
                  state_ff <= ST_IDLE;
               end else if (deliver) begin
                  if (have_hold_ff) begin
                     rsp_valid            <= 1'b1;
                     rsp_kind             <= cdb_pkg::KIND_DELIVERED;
                     rsp_originator_res   <= hold_ff.origin;
                     rsp_seq_num_res      <= hold_ff.seq;
                     rsp_clock_vector_res <= hold_ff.vc;
                     rsp_last             <= 1'b0;
                  end
                  hold_ff      <= cur;
                  have_hold_ff <= 1'b1;
                  if ((32'(cur.origin) < NUM_PROCESSES) && (clk_o != CLOCK_MAX)) begin
                     lc_ff[cur.origin] <= clk_o + CLOCK_WIDTH'(1);
                  end
                  for (int j = 0; j < PENDING_DEPTH - 1; j++) begin
                     if (IW'(j) >= k_ff[IW-1:0]) begin
                        pend_ff[j] <= pend_ff[j+1];
                     end
                  end
                  count_ff <= count_ff - CW'(1);
                  k_ff     <= '0;
               end else begin
                  k_ff <= k_ff + CW'(1);
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule

### rtl/causal_delivery_buffer_core.sv
// ----------------------------------------------------------------------------
// causal_delivery_buffer_core
// Causal delivery buffer with vector clocks: front queue plus scan engine.
// ----------------------------------------------------------------------------
// A send or a drop is registered in the queue, then answered by the engine.
// A receive is appended, then the buffer is scanned entry by entry; the scan
// restarts at the head after each delivery.
// The engine takes items only when idle; a two-entry queue hides short stalls.
// Results are one-cycle strobes; the receiver cannot stall them.
// Reset (synchronous): clocks, buffer fill and queue clear.
module causal_delivery_buffer_core #(
   parameter int NUM_PROCESSES = 4,
   parameter int PENDING_DEPTH = 16,
   parameter int CLOCK_WIDTH   = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic                            req_op,
   input  logic [1:0]                      req_originator,
   input  logic [cdb_pkg::SLOT_WIDTH-1:0]  req_seq_num,
   input  logic [cdb_pkg::VEC_WIDTH-1:0]   req_clock_vector,
   input  logic                            csr_we,
   input  logic                            csr_index,
   input  logic [15:0]                     csr_wdata,
   output logic                            rsp_valid,
   output logic [1:0]                      rsp_kind,
   output logic [1:0]                      rsp_originator_res,
   output logic [cdb_pkg::SLOT_WIDTH-1:0]  rsp_seq_num_res,
   output logic [cdb_pkg::VEC_WIDTH-1:0]   rsp_clock_vector_res,
   output logic                            rsp_last
);

   // configuration registers
   logic [1:0]  my_process_ff;
   logic [15:0] dep_matrix_ff;

   cdb_pkg::cmd_link_type link;
   logic                  take;

   // write configuration only while the block is idle (a user rule, unenforced)
   always_ff @(posedge clock) begin
      if (reset) begin
         my_process_ff <= '0;
         dep_matrix_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            cdb_pkg::CSR_MY_PROCESS: my_process_ff <= csr_wdata[1:0];
            cdb_pkg::CSR_DEP_MATRIX: dep_matrix_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // front: accept, classify and queue items
   cdb_front u_front (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_op           (req_op),
      .req_originator   (req_originator),
      .req_seq_num      (req_seq_num),
      .req_clock_vector (req_clock_vector),
      .link             (link),
      .take             (take)
   );

   // back: carry out sends, append receives, scan and deliver
   cdb_back #(
      .NUM_PROCESSES (NUM_PROCESSES),
      .PENDING_DEPTH (PENDING_DEPTH),
      .CLOCK_WIDTH   (CLOCK_WIDTH)
   ) u_back (
      .clock                (clock),
      .reset                (reset),
      .link                 (link),
      .take                 (take),
      .my_process           (my_process_ff),
      .dep_matrix           (dep_matrix_ff),
      .rsp_valid            (rsp_valid),
      .rsp_kind             (rsp_kind),
      .rsp_originator_res   (rsp_originator_res),
      .rsp_seq_num_res      (rsp_seq_num_res),
      .rsp_clock_vector_res (rsp_clock_vector_res),
      .rsp_last             (rsp_last)
   );

endmodule

### rtl/cdb_checker.sv
// ----------------------------------------------------------------------------
// cdb_checker
// Port-level checks of the causal delivery buffer, bound to the top level.
// ----------------------------------------------------------------------------
module cdb_checker (
   input logic        clock,
   input logic        reset,
   input logic        busy,
   input logic        rsp_valid,
   input logic [1:0]  rsp_kind,
   input logic [1:0]  rsp_originator_res,
   input logic [15:0] rsp_seq_num_res,
   input logic [63:0] rsp_clock_vector_res,
   input logic        rsp_last
);

   // single-result kinds always close their item
   a_single_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind != cdb_pkg::KIND_DELIVERED) |-> rsp_last)
      else $error("non-delivery result without last");

   // an empty scan reports a zeroed payload
   a_none_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == cdb_pkg::KIND_NONE) |->
      (rsp_originator_res == 2'd0) && (rsp_seq_num_res == 16'd0) &&
      (rsp_clock_vector_res == 64'd0))
      else $error("nothing-delivered result with payload");

   // reset leaves the block ready and silent
   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !busy && !rsp_valid)
      else $error("busy or result right after reset");

endmodule

bind causal_delivery_buffer_core cdb_checker u_cdb_checker (
   .clock                (clock),
   .reset                (reset),
   .busy                 (busy),
   .rsp_valid            (rsp_valid),
   .rsp_kind             (rsp_kind),
   .rsp_originator_res   (rsp_originator_res),
   .rsp_seq_num_res      (rsp_seq_num_res),
   .rsp_clock_vector_res (rsp_clock_vector_res),
   .rsp_last             (rsp_last)
);

### bench/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives send and receive items into the causal delivery buffer, predicts
// every delivered, dropped, sent and empty-scan result from a local copy of
// the vector clocks and pending buffer, and compares each strobed result.
// ----------------------------------------------------------------------------
module testbench;

   localparam int NPROC = 4;
   localparam int DEPTH = 16;
   localparam int CMAX  = 65535;

   typedef struct packed {
      logic [1:0]  kind;
      logic [1:0]  orig;
      logic [15:0] seq;
      logic [63:0] vec;
      logic        last;
   } outcome_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic        req_op = 1'b0;
   logic [1:0]  req_originator = '0;
   logic [15:0] req_seq_num = '0;
   logic [63:0] req_clock_vector = '0;
   logic        csr_we = 1'b0;
   logic        csr_index = 1'b0;
   logic [15:0] csr_wdata = '0;
   logic        rsp_valid;
   logic [1:0]  rsp_kind;
   logic [1:0]  rsp_originator_res;
   logic [15:0] rsp_seq_num_res;
   logic [63:0] rsp_clock_vector_res;
   logic        rsp_last;

   causal_delivery_buffer_core dut (.*);

   always #2 clock = ~clock;

   // predictor copy of the block state
   logic [1:0]  self_id;
   logic [15:0] dep_bits;
   logic [15:0] vclock [NPROC];
   logic [1:0]  buf_orig [DEPTH];
   logic [15:0] buf_seq [DEPTH];
   logic [63:0] buf_vec [DEPTH];
   int          buf_fill;

   outcome_type expected_q[$];
   int          mismatches = 0;
   int          send_idle_pct = 0;

   function automatic logic depends(int i, int j);
      return dep_bits[i*4+j];
   endfunction

   function automatic logic entry_ready(int k);
      int o;
      o = buf_orig[k];
      if (buf_seq[k] > 17'(vclock[o]) + 17'd1) return 1'b0;
      for (int j = 0; j < NPROC; j++)
         if (depends(o, j) && buf_vec[k][16*j +: 16] > vclock[j]) return 1'b0;
      return 1'b1;
   endfunction

   // append one prediction at the tail
   task automatic expect_outcome(outcome_type r);
      expected_q.insert(expected_q.size(), r);
   endtask

   task automatic predict_item(logic op, logic [1:0] orig, logic [15:0] seq,
                               logic [63:0] vec);
      outcome_type r;
      int k, n;
      logic [63:0] w;
      if (op == cdb_pkg::OP_SEND) begin
         w = '0;
         for (int j = 0; j < NPROC; j++)
            if (depends(self_id, j)) w[16*j +: 16] = vclock[j];
         expect_outcome('{cdb_pkg::KIND_SENT, self_id, seq, w, 1'b1});
         return;
      end
      if (buf_fill >= DEPTH) begin
         expect_outcome('{cdb_pkg::KIND_DROPPED, orig, seq, vec, 1'b1});
         return;
      end
      buf_orig[buf_fill] = orig;
      buf_seq[buf_fill] = seq;
      buf_vec[buf_fill] = vec;
      buf_fill++;
      k = 0;
      n = 0;
      while (k < buf_fill) begin
         if (entry_ready(k)) begin
            r = '{cdb_pkg::KIND_DELIVERED, buf_orig[k], buf_seq[k], buf_vec[k], 1'b0};
            expect_outcome(r);
            n++;
            if (vclock[buf_orig[k]] != CMAX) vclock[buf_orig[k]]++;
            for (int j = k; j + 1 < buf_fill; j++) begin
               buf_orig[j] = buf_orig[j+1];
               buf_seq[j] = buf_seq[j+1];
               buf_vec[j] = buf_vec[j+1];
            end
            buf_fill--;
            k = 0;
         end else begin
            k++;
         end
      end
      if (n == 0) expect_outcome('{cdb_pkg::KIND_NONE, 2'd0, 16'd0, 64'd0, 1'b1});
      else expected_q[$].last = 1'b1;
   endtask

   // send one item: random gap, then hold start until accepted
   task automatic send_item(logic op, logic [1:0] orig, logic [15:0] seq,
                            logic [63:0] vec);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         start <= 1'b0;
         @(negedge clock);
      end
      start <= 1'b1;
      req_op <= op;
      req_originator <= orig;
      req_seq_num <= seq;
      req_clock_vector <= vec;
      @(posedge clock);
      while (busy) @(posedge clock);
      predict_item(op, orig, seq, vec);
   endtask

   // drop start, drain all results, then allow the scan pipeline to settle
   task automatic wait_idle();
      @(negedge clock);
      start <= 1'b0;
      while (expected_q.size() != 0) @(negedge clock);
      repeat (40) @(negedge clock);
   endtask

   task automatic write_reg(logic idx, logic [15:0] val);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
      if (idx == cdb_pkg::CSR_MY_PROCESS) self_id = val[1:0];
      else dep_bits = val;
   endtask

   // compare each strobed result with the oldest prediction
   always @(posedge clock) begin
      outcome_type want;
      if (!reset && rsp_valid) begin
         if (expected_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result kind %0d", rsp_kind);
         end else begin
            want = expected_q.pop_front();
            if (rsp_kind !== want.kind || rsp_originator_res !== want.orig ||
                rsp_seq_num_res !== want.seq || rsp_clock_vector_res !== want.vec ||
                rsp_last !== want.last) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: exp %0d %0d %h %h %0d got %0d %0d %h %h %0d",
                     want.kind, want.orig, want.seq, want.vec, want.last, rsp_kind,
                     rsp_originator_res, rsp_seq_num_res, rsp_clock_vector_res,
                     rsp_last);
            end
         end
      end
   end

   // directed: sends, full buffer, sequence zero, outside deps
   task automatic test_directed();
      write_reg(cdb_pkg::CSR_MY_PROCESS, 16'd3);
      write_reg(cdb_pkg::CSR_DEP_MATRIX, 16'hFFFF);
      send_item(cdb_pkg::OP_SEND, 2'd0, 16'hFFFF, '1);
      send_item(cdb_pkg::OP_RECEIVE, 2'd1, 16'd0, 64'd0);
      send_item(cdb_pkg::OP_RECEIVE, 2'd1, 16'd1, 64'd0);
      send_item(cdb_pkg::OP_RECEIVE, 2'd2, 16'd5, 64'd0);
      send_item(cdb_pkg::OP_RECEIVE, 2'd0, 16'd1, '1);
      send_item(cdb_pkg::OP_SEND, 2'd3, 16'd1, 64'd0);
      // fill the buffer with undeliverable items, then overflow it
      for (int i = 0; i < DEPTH; i++)
         send_item(cdb_pkg::OP_RECEIVE, 2'(i), 16'hFFFF, '1);
      send_item(cdb_pkg::OP_RECEIVE, 2'd2, 16'h1234, 64'hDEAD_BEEF_0123_4567);
      send_item(cdb_pkg::OP_SEND, 2'd0, 16'd7, 64'd0);
      wait_idle();
   endtask

   // random: mostly deliverable-ish traffic with occasional noise
   task automatic test_random(int count, int idle);
      logic [1:0]  o;
      logic [15:0] s;
      logic [63:0] v;
      send_idle_pct = idle;
      for (int i = 0; i < count; i++) begin
         o = 2'($urandom_range(3));
         v = '0;
         for (int j = 0; j < NPROC; j++)
            v[16*j +: 16] = ($urandom_range(9) == 0) ? 16'($urandom)
                                                     : vclock[j] + 16'($urandom_range(1));
         s = ($urandom_range(19) == 0) ? 16'($urandom)
                                       : vclock[o] + 16'($urandom_range(2));
         if ($urandom_range(4) == 0) send_item(cdb_pkg::OP_SEND, o, 16'($urandom), v);
         else send_item(cdb_pkg::OP_RECEIVE, o, s, v);
      end
      wait_idle();
   endtask

   initial begin
      for (int i = 0; i < NPROC; i++) vclock[i] = '0;
      self_id = '0;
      dep_bits = '0;
      buf_fill = 0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      write_reg(cdb_pkg::CSR_MY_PROCESS, 16'd0);
      write_reg(cdb_pkg::CSR_DEP_MATRIX, 16'h0000);
      test_random(60, 22);
      write_reg(cdb_pkg::CSR_MY_PROCESS, 16'd1);
      write_reg(cdb_pkg::CSR_DEP_MATRIX, 16'($urandom));
      test_random(140, 75);
      write_reg(cdb_pkg::CSR_MY_PROCESS, 16'd2);
      write_reg(cdb_pkg::CSR_DEP_MATRIX, 16'hFFFF);
      test_random(140, 0);
      write_reg(cdb_pkg::CSR_MY_PROCESS, 16'($urandom_range(3)));
      write_reg(cdb_pkg::CSR_DEP_MATRIX, 16'($urandom));
      test_random(80, 0);
      if (mismatches == 0) $display("Test completed successfully");
      else $display("Test completed with failures");
      $finish;
   end

   initial begin
      #2000000;
      $display("Test completed with failures");
      $finish;
   end

endmodule
